/* rtl/cbri_pkg.sv */
// ----------------------------------------------------------------------------
// cbri_pkg
// Shared types and constants for the CPU bus register interface.
// ----------------------------------------------------------------------------
package cbri_pkg;

	typedef enum logic [2:0] {
		KIND_READ   = 3'd0,
		KIND_WRITE  = 3'd1,
		KIND_VSYNC  = 3'd2,
		KIND_SIGINT = 3'd3,
		KIND_RX     = 3'd4,
		KIND_DRAIN  = 3'd5
	} kind_t;

	localparam logic [4:0] OFF_UART_FLAGS = 5'h00;
	localparam logic [4:0] OFF_UART_TX    = 5'h01;
	localparam logic [4:0] OFF_UART_RX    = 5'h02;
	localparam logic [4:0] OFF_P0_DATA    = 5'h04;
	localparam logic [4:0] OFF_P0_STEP    = 5'h05;
	localparam logic [4:0] OFF_P0_LO      = 5'h06;
	localparam logic [4:0] OFF_P0_HI      = 5'h07;
	localparam logic [4:0] OFF_P1_DATA    = 5'h08;
	localparam logic [4:0] OFF_P1_STEP    = 5'h09;
	localparam logic [4:0] OFF_P1_LO      = 5'h0A;
	localparam logic [4:0] OFF_P1_HI      = 5'h0B;
	localparam logic [4:0] OFF_STACK      = 5'h0C;
	localparam logic [4:0] OFF_OS_OP      = 5'h0F;
	localparam logic [4:0] OFF_IRQ        = 5'h10;

	localparam int BIT_VSYNC   = 7;
	localparam int BIT_SIGINT  = 6;
	localparam int BIT_TX_OK   = 7;
	localparam int BIT_RX_HAVE = 6;

	localparam logic [7:0] OS_OP_DROP = 8'h00;

	typedef struct packed {
		logic        tx_empty;
		logic        rx_ready;
		logic [7:0]  tx_byte;
		logic        tx_valid;
		logic [7:0]  mem_wr_data;
		logic [15:0] mem_wr_addr;
		logic        mem_wr_valid;
		logic        irq_n;
		logic [7:0]  read_data;
	} result_t;

endpackage

/* rtl/cbri_ram.sv */
// ----------------------------------------------------------------------------
// cbri_ram
// Generic RAM: one write port, two registered read ports, new data on
// a read of the address being written.
// ----------------------------------------------------------------------------
module cbri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && waddr == raddr_a) begin
			rdata_a <= wdata;
		end else begin
			rdata_a <= mem[raddr_a];
		end
		if (we && waddr == raddr_b) begin
			rdata_b <= wdata;
		end else begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* rtl/cpu_bus_register_interface_top.sv */
// ----------------------------------------------------------------------------
// cpu_bus_register_interface_top
// 32-byte register window with memory portals, stack, IRQ and UART.
// ----------------------------------------------------------------------------
// Takes one item per clock while the master side does not stall; its result
// is registered and appears on the master side the cycle after acceptance.
// The portal data bytes, the stack top and the next transmit ring byte to
// drain are read from RAMs addressed by the next state each cycle, so no item
// waits on a memory. After reset the extended memory is cleared one entry per
// cycle and no item is taken until that pass ends.
module cpu_bus_register_interface_top
	import cbri_pkg::*;
#(
	parameter int MEM_ADDR_BITS = 16,
	parameter int STACK_DEPTH   = 512,
	parameter int TX_RING_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // kind[2:0], offset[7:3], data[15:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], irq_n[8], mem_wr_valid[9], mem_wr_addr[25:10],
	// mem_wr_data[33:26], tx_valid[34], tx_byte[42:35], rx_ready[43],
	// tx_empty[44], zero[47:45]
	output logic [47:0] m_axis_tdata
);

	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int ST_AW = $clog2(STACK_DEPTH);
	localparam int TX_AW = $clog2(TX_RING_DEPTH);
	localparam logic [SP_W-1:0]  SP_EMPTY = SP_W'(STACK_DEPTH);
	localparam logic [TX_AW-1:0] TX_LAST  = TX_AW'(TX_RING_DEPTH - 1);

	function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] x);
		return (x == TX_LAST) ? '0 : x + 1'b1;
	endfunction

	logic [7:0] win_q [32];
	logic [7:0] win_v [32];
	logic [7:0] win_d [32];

	logic [SP_W-1:0]  sp_q, sp_d;
	logic [7:0]       mask_q, mask_d;
	logic             vs_q, vs_d, si_q, si_d;
	logic [7:0]       rxb_q, rxb_d;
	logic             rxf_q, rxf_d;
	logic [TX_AW-1:0] head_q, head_d, tail_q, tail_d;

	logic                     clearing_q;
	logic [MEM_ADDR_BITS-1:0] clr_cnt_q;

	logic [7:0] ext_q0, ext_q1, st_q, tx_q;

	logic                     ext_we;
	logic [MEM_ADDR_BITS-1:0] ext_waddr;
	logic                     st_we;
	logic [ST_AW-1:0]         st_waddr;
	logic                     tx_we;

	logic    acc;
	kind_t   kind;
	logic [4:0] off;
	logic [7:0] dat;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	assign kind = kind_t'(s_axis_tdata[2:0]);
	assign off  = s_axis_tdata[7:3];
	assign dat  = s_axis_tdata[15:8];

	assign s_axis_tready = !clearing_q && (!out_valid_q || m_axis_tready);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			win_v[i] = win_q[i];
		end
		win_v[OFF_P0_DATA] = ext_q0;
		win_v[OFF_P1_DATA] = ext_q1;
		win_v[OFF_STACK]   = (sp_q == SP_EMPTY) ? 8'h00 : st_q;
		win_v[OFF_IRQ]     = {vs_q, si_q, 6'b000000};
	end

	always_comb begin
		logic             w;
		logic [4:0]       i_step, i_lo, i_hi;
		logic [15:0]      ptr, ptr_n;
		logic [7:0]       fl;
		logic [TX_AW-1:0] nx;

		for (int i = 0; i < 32; i++) begin
			win_d[i] = win_q[i];
		end
		sp_d   = sp_q;
		mask_d = mask_q;
		vs_d   = vs_q;
		si_d   = si_q;
		rxb_d  = rxb_q;
		rxf_d  = rxf_q;
		head_d = head_q;
		tail_d = tail_q;
		ext_we    = 1'b0;
		ext_waddr = '0;
		st_we     = 1'b0;
		st_waddr  = '0;
		tx_we     = 1'b0;
		res       = '0;
		w      = (kind == KIND_WRITE);
		i_step = (off == OFF_P1_DATA) ? OFF_P1_STEP : OFF_P0_STEP;
		i_lo   = (off == OFF_P1_DATA) ? OFF_P1_LO : OFF_P0_LO;
		i_hi   = (off == OFF_P1_DATA) ? OFF_P1_HI : OFF_P0_HI;
		ptr    = {win_q[i_hi], win_q[i_lo]};
		ptr_n  = ptr + {{8{win_q[i_step][7]}}, win_q[i_step]};
		fl     = win_q[OFF_UART_FLAGS];
		nx     = tx_inc(head_q);

		res.read_data = win_v[off];

		if (acc) begin
			case (kind)
				KIND_READ, KIND_WRITE: begin
					if (w) begin
						win_d[off] = dat;
					end
					if (off == OFF_IRQ) begin
						if (w) begin
							mask_d = dat;
						end
						if (dat[BIT_VSYNC]) begin
							vs_d = 1'b0;
						end
						if (dat[BIT_SIGINT]) begin
							si_d = 1'b0;
						end
					end else if (off == OFF_OS_OP && w) begin
						if (dat == OS_OP_DROP) begin
							sp_d = SP_EMPTY;
						end
					end else if (off == OFF_STACK) begin
						if (w) begin
							if (sp_q != '0) begin
								sp_d     = sp_q - 1'b1;
								st_we    = 1'b1;
								st_waddr = sp_d[ST_AW-1:0];
							end
						end else if (sp_q != SP_EMPTY) begin
							sp_d = sp_q + 1'b1;
						end
					end else if (off == OFF_P0_DATA || off == OFF_P1_DATA) begin
						if (w) begin
							ext_we    = 1'b1;
							ext_waddr = MEM_ADDR_BITS'(ptr);
							res.mem_wr_valid = 1'b1;
							res.mem_wr_addr  = 16'(ext_waddr);
							res.mem_wr_data  = dat;
						end
						win_d[i_lo] = ptr_n[7:0];
						win_d[i_hi] = ptr_n[15:8];
					end else if (off == OFF_UART_RX && !w) begin
						if (rxf_q) begin
							win_d[OFF_UART_RX] = rxb_q;
							win_d[OFF_UART_FLAGS][BIT_RX_HAVE] = 1'b1;
							rxf_d = 1'b0;
						end else begin
							win_d[OFF_UART_FLAGS][BIT_RX_HAVE] = 1'b0;
							win_d[OFF_UART_RX] = 8'h00;
						end
					end else if (off == OFF_UART_TX && w) begin
						if (nx != tail_q) begin
							tx_we  = 1'b1;
							head_d = nx;
						end
						win_d[OFF_UART_FLAGS][BIT_TX_OK] = (tx_inc(head_d) != tail_q);
					end else if (off == OFF_UART_FLAGS && !w) begin
						if (!fl[BIT_RX_HAVE] && rxf_q) begin
							win_d[OFF_UART_RX] = rxb_q;
							fl[BIT_RX_HAVE]    = 1'b1;
							rxf_d              = 1'b0;
						end
						fl[BIT_TX_OK] = (nx != tail_q);
						win_d[OFF_UART_FLAGS] = fl;
					end
				end
				KIND_VSYNC: begin
					vs_d = 1'b1;
				end
				KIND_SIGINT: begin
					si_d = 1'b1;
				end
				KIND_RX: begin
					rxb_d = dat;
					rxf_d = 1'b1;
				end
				KIND_DRAIN: begin
					if (head_q != tail_q) begin
						tail_d       = tx_inc(tail_q);
						res.tx_valid = 1'b1;
						res.tx_byte  = tx_q;
					end
				end
				default: begin
				end
			endcase
		end

		res.irq_n    = (({vs_d, si_d, 6'b000000} & mask_d) == 8'h00);
		res.rx_ready = !rxf_d && !win_d[OFF_UART_FLAGS][BIT_RX_HAVE];
		res.tx_empty = (head_d == tail_d);
	end

	cbri_ram #(.WIDTH(8), .DEPTH(2 ** MEM_ADDR_BITS)) u_ext_ram (
		.clk     (clk),
		.we      (clearing_q || ext_we),
		.waddr   (clearing_q ? clr_cnt_q : ext_waddr),
		.wdata   (clearing_q ? 8'h00 : dat),
		.raddr_a (MEM_ADDR_BITS'({win_d[OFF_P0_HI], win_d[OFF_P0_LO]})),
		.rdata_a (ext_q0),
		.raddr_b (MEM_ADDR_BITS'({win_d[OFF_P1_HI], win_d[OFF_P1_LO]})),
		.rdata_b (ext_q1)
	);

	cbri_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk     (clk),
		.we      (st_we),
		.waddr   (st_waddr),
		.wdata   (dat),
		.raddr_a (sp_d[ST_AW-1:0]),
		.rdata_a (st_q),
		.raddr_b (sp_d[ST_AW-1:0]),
		.rdata_b ()
	);

	cbri_ram #(.WIDTH(8), .DEPTH(TX_RING_DEPTH)) u_tx_ram (
		.clk     (clk),
		.we      (tx_we),
		.waddr   (head_d),
		.wdata   (dat),
		.raddr_a (tx_inc(tail_d)),
		.rdata_a (tx_q),
		.raddr_b (tx_inc(tail_d)),
		.rdata_b ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				win_q[i] <= 8'h00;
			end
			sp_q        <= SP_EMPTY;
			mask_q      <= 8'h00;
			vs_q        <= 1'b0;
			si_q        <= 1'b0;
			rxb_q       <= 8'h00;
			rxf_q       <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < 32; i++) begin
				win_q[i] <= win_d[i];
			end
			sp_q   <= sp_d;
			mask_q <= mask_d;
			vs_q   <= vs_d;
			si_q   <= si_d;
			rxb_q  <= rxb_d;
			rxf_q  <= rxf_d;
			head_q <= head_d;
			tail_q <= tail_d;
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_q <= res;
		end
	end

endmodule
